### rtl/scancode_keyboard_latch_joystick_macros.svh
// Assertion helpers shared by the keyboard latch and joystick RTL.
`ifndef SCANCODE_KEYBOARD_LATCH_JOYSTICK_MACROS_SVH
`define SCANCODE_KEYBOARD_LATCH_JOYSTICK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKLJ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKLJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sklj_pkg.sv
package sklj_pkg;

   // Input transaction kinds.
   localparam logic [1:0] MODE_KEY    = 2'd0;
   localparam logic [1:0] MODE_STROBE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STICK_STEP = 2'd0;
   localparam logic [1:0] CSR_STICK_MODE = 2'd1;
   localparam logic [1:0] CSR_CENTRE_X   = 2'd2;
   localparam logic [1:0] CSR_CENTRE_Y   = 2'd3;

   // Stick modes.
   localparam logic [1:0] STICK_PROP  = 2'd0;
   localparam logic [1:0] STICK_FORCE = 2'd2;

   // Scancodes with a fixed role.
   localparam logic [6:0] SC_REPEAT = 7'd26;
   localparam logic [6:0] SC_LCTRL  = 7'd29;
   localparam logic [6:0] SC_RCTRL  = 7'd97;
   localparam logic [6:0] SC_LSHIFT = 7'd42;
   localparam logic [6:0] SC_RSHIFT = 7'd54;
   localparam logic [6:0] SC_UP     = 7'd72;
   localparam logic [6:0] SC_LEFT   = 7'd75;
   localparam logic [6:0] SC_CENTRE = 7'd76;
   localparam logic [6:0] SC_RIGHT  = 7'd77;
   localparam logic [6:0] SC_DOWN   = 7'd80;
   localparam logic [6:0] SC_RESET  = 7'd99;
   localparam logic [6:0] SC_BTN1   = 7'd107;
   localparam logic [6:0] SC_BTN2   = 7'd109;
   localparam logic [6:0] SC_BTN0   = 7'd111;
   localparam logic [6:0] SC_BOOT   = 7'd119;
   localparam logic [6:0] SC_F1     = 7'd59;
   localparam logic [6:0] SC_F10    = 7'd68;
   localparam logic [6:0] SC_LOW_END = 7'd56;

   localparam logic [7:0] STROBE_BIT = 8'h80;
   localparam logic [8:0] AXIS_MAX   = 9'd255;
   localparam logic [8:0] AXIS_FORCE = 9'd256;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_KEY,
      OP_STROBE,
      OP_TICK,
      OP_IDLE
   } op_kind_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_CHAR,
      ACT_RESET,
      ACT_BOOT,
      ACT_CENTRE,
      ACT_BTN0,
      ACT_BTN1,
      ACT_BTN2,
      ACT_FKEY
   } key_act_type;

   typedef struct packed {
      key_act_type act;
      logic [6:0]  ch_plain;
      logic [6:0]  ch_ctrl;
      logic [6:0]  ch_shift;
      logic [3:0]  fkey;
   } key_info_type;

   typedef struct packed {
      op_kind_type  kind;
      logic [6:0]   scan_code;
      logic         is_press;
      key_info_type info;
   } op_type;

   // Characters of the lower keys, padded to a power of two with zeros.
   localparam logic [6:0] LOW_PLAIN [64] = '{
      7'd0,  7'd27, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
      7'd55, 7'd56, 7'd57, 7'd48, 7'd58, 7'd45, 7'd8,  7'd27,
      7'd81, 7'd87, 7'd69, 7'd82, 7'd84, 7'd89, 7'd85, 7'd73,
      7'd79, 7'd80, 7'd0,  7'd8,  7'd13, 7'd0,  7'd65, 7'd83,
      7'd68, 7'd70, 7'd71, 7'd72, 7'd74, 7'd75, 7'd76, 7'd59,
      7'd8,  7'd0,  7'd0,  7'd21, 7'd90, 7'd88, 7'd67, 7'd86,
      7'd66, 7'd78, 7'd77, 7'd44, 7'd46, 7'd47, 7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0};

   localparam logic [6:0] LOW_CTRL [64] = '{
      7'd0,  7'd27, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
      7'd55, 7'd56, 7'd57, 7'd48, 7'd58, 7'd45, 7'd8,  7'd27,
      7'd17, 7'd23, 7'd5,  7'd18, 7'd20, 7'd25, 7'd21, 7'd9,
      7'd15, 7'd16, 7'd0,  7'd8,  7'd13, 7'd0,  7'd1,  7'd19,
      7'd4,  7'd6,  7'd7,  7'd8,  7'd10, 7'd11, 7'd12, 7'd59,
      7'd8,  7'd0,  7'd0,  7'd21, 7'd26, 7'd24, 7'd3,  7'd22,
      7'd2,  7'd14, 7'd13, 7'd44, 7'd46, 7'd47, 7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0};

   localparam logic [6:0] LOW_SHIFT [64] = '{
      7'd0,  7'd27, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
      7'd39, 7'd40, 7'd41, 7'd48, 7'd42, 7'd61, 7'd8,  7'd27,
      7'd81, 7'd87, 7'd69, 7'd82, 7'd84, 7'd89, 7'd85, 7'd73,
      7'd79, 7'd80, 7'd0,  7'd8,  7'd13, 7'd0,  7'd65, 7'd83,
      7'd68, 7'd70, 7'd71, 7'd72, 7'd74, 7'd75, 7'd76, 7'd43,
      7'd8,  7'd0,  7'd0,  7'd21, 7'd90, 7'd88, 7'd67, 7'd86,
      7'd66, 7'd78, 7'd77, 7'd60, 7'd62, 7'd63, 7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0};

   // Decode a scancode into its action and its character in each keymap.
   function automatic key_info_type classify_key(input logic [6:0] sc);
      key_info_type info;
      info = '{act: ACT_NONE, ch_plain: '0, ch_ctrl: '0, ch_shift: '0, fkey: '0};
      if (sc < SC_LOW_END) begin
         info.ch_plain = LOW_PLAIN[sc[5:0]];
         info.ch_ctrl  = LOW_CTRL[sc[5:0]];
         info.ch_shift = LOW_SHIFT[sc[5:0]];
         case (sc) inside
            7'd0, SC_REPEAT, SC_LCTRL, 7'd41, SC_LSHIFT, SC_RSHIFT, 7'd55: begin
               info.act = ACT_NONE;
            end
            default: begin
               info.act = ACT_CHAR;
            end
         endcase
      end else begin
         case (sc) inside
            7'd57: begin
               info.act = ACT_CHAR;
               info.ch_plain = 7'd32;
               info.ch_ctrl = 7'd32;
               info.ch_shift = 7'd32;
            end
            7'd105: begin
               info.act = ACT_CHAR;
               info.ch_plain = 7'd8;
               info.ch_ctrl = 7'd8;
               info.ch_shift = 7'd8;
            end
            7'd106: begin
               info.act = ACT_CHAR;
               info.ch_plain = 7'd21;
               info.ch_ctrl = 7'd21;
               info.ch_shift = 7'd21;
            end
            [SC_F1:SC_F10]: begin
               info.act = ACT_FKEY;
               info.fkey = 4'(sc - (SC_F1 - 7'd1));
            end
            SC_CENTRE: info.act = ACT_CENTRE;
            SC_RESET:  info.act = ACT_RESET;
            SC_BOOT:   info.act = ACT_BOOT;
            SC_BTN0:   info.act = ACT_BTN0;
            SC_BTN1:   info.act = ACT_BTN1;
            SC_BTN2:   info.act = ACT_BTN2;
            default:   info.act = ACT_NONE;
         endcase
      end
      return info;
   endfunction

endpackage

### rtl/scancode_keyboard_latch_joystick.sv
// Keyboard latch and emulated joystick. Every input transaction (key event, strobe read or
// timer tick) yields exactly one result transaction carrying the latch, stick position,
// buttons and the reset, boot and function-key pulses after that transaction. The block
// sustains one transaction per clock while rsp_ready drains results: a front decoder
// classifies the scancode, a two-entry queue decouples it from the back end, and the back
// end applies one transaction per cycle to the held-key bitmap and stick registers. A
// result is registered in the result slot after the transaction has passed the queue.
// Configuration writes take effect at once and belong in idle periods.
module scancode_keyboard_latch_joystick
   import sklj_pkg::*;
#(
   parameter int unsigned SCAN_CODES = 128
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [6:0] req_scan_code,
   input  logic       req_is_press,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_latch_value,
   output logic [8:0] rsp_stick_x,
   output logic [8:0] rsp_stick_y,
   output logic [2:0] rsp_buttons,
   output logic       rsp_reset_request,
   output logic       rsp_boot_request,
   output logic [3:0] rsp_function_key,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   op_type front_op;
   logic   front_valid;
   logic   front_ready;
   op_type back_op;
   logic   back_valid;
   logic   back_ready;

   sklj_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_scan_code (req_scan_code),
      .req_is_press  (req_is_press),
      .op_valid      (front_valid),
      .op_ready      (front_ready),
      .op            (front_op)
   );

   sklj_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_op     (front_op),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_op    (back_op)
   );

   sklj_back #(
      .SCAN_CODES (SCAN_CODES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (back_valid),
      .op_ready          (back_ready),
      .op                (back_op),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_latch_value   (rsp_latch_value),
      .rsp_stick_x       (rsp_stick_x),
      .rsp_stick_y       (rsp_stick_y),
      .rsp_buttons       (rsp_buttons),
      .rsp_reset_request (rsp_reset_request),
      .rsp_boot_request  (rsp_boot_request),
      .rsp_function_key  (rsp_function_key)
   );

endmodule

### rtl/sklj_front.sv
module sklj_front
   import sklj_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [6:0] req_scan_code,
   input  logic       req_is_press,
   output logic       op_valid,
   input  logic       op_ready,
   output op_type     op
);

   // Handshake passes straight to the queue.
   assign op_valid  = req_valid;
   assign req_ready = op_ready;

   // Classify the transaction and decode the key independent of held state.
   always_comb begin
      case (req_mode)
         MODE_KEY:    op.kind = OP_KEY;
         MODE_STROBE: op.kind = OP_STROBE;
         MODE_TICK:   op.kind = OP_TICK;
         default:     op.kind = OP_IDLE;
      endcase
      op.scan_code = req_scan_code;
      op.is_press  = req_is_press;
      op.info      = classify_key(req_scan_code);
   end

endmodule

### rtl/sklj_queue.sv
`include "scancode_keyboard_latch_joystick_macros.svh"

module sklj_queue
   import sklj_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  op_type in_op,
   output logic   out_valid,
   input  logic   out_ready,
   output op_type out_op
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_op    = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_op;
      end
   end

   `SKLJ_ASSERT_NEXT(a_queue_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `SKLJ_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "queue over capacity")

endmodule

### rtl/sklj_back.sv
`include "scancode_keyboard_latch_joystick_macros.svh"

module sklj_back
   import sklj_pkg::*;
#(
   parameter int unsigned SCAN_CODES = 128
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       op_valid,
   output logic       op_ready,
   input  op_type     op,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_latch_value,
   output logic [8:0] rsp_stick_x,
   output logic [8:0] rsp_stick_y,
   output logic [2:0] rsp_buttons,
   output logic       rsp_reset_request,
   output logic       rsp_boot_request,
   output logic [3:0] rsp_function_key
);

   localparam int unsigned IDX_W = $clog2(SCAN_CODES);
   localparam logic [IDX_W-1:0] IX_REPEAT = IDX_W'(SC_REPEAT);
   localparam logic [IDX_W-1:0] IX_LCTRL  = IDX_W'(SC_LCTRL);
   localparam logic [IDX_W-1:0] IX_RCTRL  = IDX_W'(SC_RCTRL);
   localparam logic [IDX_W-1:0] IX_LSHIFT = IDX_W'(SC_LSHIFT);
   localparam logic [IDX_W-1:0] IX_RSHIFT = IDX_W'(SC_RSHIFT);
   localparam logic [IDX_W-1:0] IX_UP     = IDX_W'(SC_UP);
   localparam logic [IDX_W-1:0] IX_DOWN   = IDX_W'(SC_DOWN);
   localparam logic [IDX_W-1:0] IX_LEFT   = IDX_W'(SC_LEFT);
   localparam logic [IDX_W-1:0] IX_RIGHT  = IDX_W'(SC_RIGHT);

   // Configuration registers.
   logic [7:0] stick_step_ff;
   logic [1:0] stick_mode_ff;
   logic [7:0] centre_x_ff;
   logic [7:0] centre_y_ff;

   // Architectural state.
   logic [SCAN_CODES-1:0] held_ff;
   logic [SCAN_CODES-1:0] held_in;
   logic [7:0]            latch_ff;
   logic [7:0]            latch_in;
   logic [8:0]            pos_x_ff;
   logic [8:0]            pos_x_in;
   logic [8:0]            pos_y_ff;
   logic [8:0]            pos_y_in;
   logic [2:0]            button_ff;
   logic [2:0]            button_in;

   // Result slot.
   logic       rsp_valid_ff;
   logic       reset_req_ff;
   logic       reset_req_in;
   logic       boot_req_ff;
   logic       boot_req_in;
   logic [3:0] fkey_ff;
   logic [3:0] fkey_in;

   logic             fire;
   logic [IDX_W-1:0] sc_idx;
   logic             was_held;
   logic             ctrl_held;
   logic             shift_held;
   logic [6:0]       ch;
   logic [8:0]       y_mid;
   logic [8:0]       x_mid;

   // Move an axis toward zero by one step, or straight to zero outside proportional mode.
   function automatic logic [8:0] step_down(input logic [8:0] v, input logic [7:0] step,
                                            input logic [1:0] smode);
      logic [8:0] res;
      if (smode != STICK_PROP) begin
         res = '0;
      end else if (v > {1'b0, step}) begin
         res = v - {1'b0, step};
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // Move an axis toward the top by one step, or straight to the top outside proportional mode.
   function automatic logic [8:0] step_up(input logic [8:0] v, input logic [7:0] step,
                                          input logic [1:0] smode);
      logic [9:0] sum;
      logic [8:0] res;
      sum = {1'b0, v} + {2'b00, step};
      if (smode != STICK_PROP) begin
         res = AXIS_MAX;
      end else if (sum < {1'b0, AXIS_MAX}) begin
         res = sum[8:0];
      end else begin
         res = AXIS_MAX;
      end
      return res;
   endfunction

   // The slot is free when empty or being drained this cycle.
   assign op_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = op_valid && op_ready;

   assign sc_idx     = IDX_W'(op.scan_code);
   assign was_held   = held_ff[sc_idx];
   assign ctrl_held  = held_ff[IX_LCTRL] || held_ff[IX_RCTRL];
   assign shift_held = held_ff[IX_LSHIFT] || held_ff[IX_RSHIFT];

   // Keymap selection by held modifiers, Ctrl over Shift.
   always_comb begin
      if (ctrl_held) begin
         ch = op.info.ch_ctrl;
      end else if (shift_held) begin
         ch = op.info.ch_shift;
      end else begin
         ch = op.info.ch_plain;
      end
   end

   // Stick motion of a tick: up then down, left then right.
   always_comb begin
      y_mid = held_ff[IX_UP] ? step_down(pos_y_ff, stick_step_ff, stick_mode_ff) : pos_y_ff;
      x_mid = held_ff[IX_LEFT] ? step_down(pos_x_ff, stick_step_ff, stick_mode_ff) : pos_x_ff;
   end

   // Next state for one transaction.
   always_comb begin
      held_in      = held_ff;
      latch_in     = latch_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      button_in    = button_ff;
      reset_req_in = 1'b0;
      boot_req_in  = 1'b0;
      fkey_in      = '0;
      case (op.kind)
         OP_KEY: begin
            if (op.is_press) begin
               if (!was_held) begin
                  held_in[sc_idx] = 1'b1;
                  if (op.info.act == ACT_CHAR) begin
                     latch_in = STROBE_BIT | {1'b0, ch};
                  end
               end
               if (was_held || op.info.act != ACT_CHAR) begin
                  case (op.info.act)
                     ACT_RESET:  reset_req_in = 1'b1;
                     ACT_BOOT:   boot_req_in = 1'b1;
                     ACT_CENTRE: begin
                        pos_x_in = {1'b0, centre_x_ff};
                        pos_y_in = {1'b0, centre_y_ff};
                     end
                     ACT_BTN0:   button_in[0] = 1'b1;
                     ACT_BTN1:   button_in[1] = 1'b1;
                     ACT_BTN2:   button_in[2] = 1'b1;
                     ACT_FKEY:   fkey_in = op.info.fkey;
                     default:    ;
                  endcase
               end
            end else begin
               held_in[sc_idx] = 1'b0;
               case (op.info.act)
                  ACT_BTN0: button_in[0] = 1'b0;
                  ACT_BTN1: button_in[1] = 1'b0;
                  ACT_BTN2: button_in[2] = 1'b0;
                  default:  ;
               endcase
            end
         end
         OP_STROBE: begin
            if (!held_ff[IX_REPEAT]) begin
               latch_in[7] = 1'b0;
            end
         end
         OP_TICK: begin
            pos_y_in = held_ff[IX_DOWN] ? step_up(y_mid, stick_step_ff, stick_mode_ff) : y_mid;
            pos_x_in = held_ff[IX_RIGHT] ? step_up(x_mid, stick_step_ff, stick_mode_ff) : x_mid;
            if (stick_mode_ff == STICK_FORCE) begin
               pos_x_in = AXIS_FORCE;
               pos_y_in = AXIS_FORCE;
            end
         end
         default: ;
      endcase
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         stick_step_ff <= 8'd2;
         stick_mode_ff <= STICK_PROP;
         centre_x_ff   <= 8'd127;
         centre_y_ff   <= 8'd127;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STICK_STEP: stick_step_ff <= csr_wdata;
            CSR_STICK_MODE: stick_mode_ff <= csr_wdata[1:0];
            CSR_CENTRE_X:   centre_x_ff <= csr_wdata;
            CSR_CENTRE_Y:   centre_y_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // State and result slot update.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         latch_ff     <= '0;
         pos_x_ff     <= 9'd127;
         pos_y_ff     <= 9'd127;
         button_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         reset_req_ff <= 1'b0;
         boot_req_ff  <= 1'b0;
         fkey_ff      <= '0;
      end else if (fire) begin
         held_ff      <= held_in;
         latch_ff     <= latch_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         button_ff    <= button_in;
         rsp_valid_ff <= 1'b1;
         reset_req_ff <= reset_req_in;
         boot_req_ff  <= boot_req_in;
         fkey_ff      <= fkey_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // State holds still while a result waits, so it drives the result directly.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_latch_value   = latch_ff;
   assign rsp_stick_x       = pos_x_ff;
   assign rsp_stick_y       = pos_y_ff;
   assign rsp_buttons       = button_ff;
   assign rsp_reset_request = reset_req_ff;
   assign rsp_boot_request  = boot_req_ff;
   assign rsp_function_key  = fkey_ff;

   `SKLJ_ASSERT_NEXT(a_strobe_clears, clock, reset, fire && op.kind == OP_STROBE && !held_ff[IX_REPEAT], !latch_ff[7], "strobe read left the strobe bit set")
   `SKLJ_ASSERT_NEXT(a_force_mode, clock, reset, fire && op.kind == OP_TICK && stick_mode_ff == STICK_FORCE, pos_x_ff == AXIS_FORCE && pos_y_ff == AXIS_FORCE, "forced stick mode did not pin axes")
   `SKLJ_ASSERT_NEXT(a_hold_on_stall, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff && latch_ff == $past(latch_ff) && pos_x_ff == $past(pos_x_ff), "state moved under a stalled result")

endmodule
